// ----- hw/rtl/gnsc_pkg.sv -----
// Package for the grid neighbor state counter.
// Holds request/result payload types, register indexes, and controller types.
// No dependencies.
`default_nettype none

package gnsc_pkg;

  localparam int TALLY_DEPTH = 16;
  localparam int MAX_OUT     = 16;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [2:0] REG_GRID_ROWS  = 3'd0;
  localparam logic [2:0] REG_GRID_COLS  = 3'd1;
  localparam logic [2:0] REG_NUM_STATES = 3'd2;
  localparam logic [2:0] REG_WRAP_EDGES = 3'd3;
  localparam logic [2:0] REG_EIGHT_NBRS = 3'd4;

  localparam logic [6:0] GRID_ROWS_RST  = 7'd64;
  localparam logic [6:0] GRID_COLS_RST  = 7'd64;
  localparam logic [4:0] NUM_STATES_RST = 5'd16;

  localparam logic [2:0] NBR_LAST = 3'd7;

  typedef struct packed {
    logic       req_type;
    logic [5:0] row;
    logic [5:0] col;
    logic [3:0] cell_state;
  } req_t;

  typedef struct packed {
    logic [3:0] state_index;
    logic [3:0] neighbor_count;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [6:0] rows;
    logic [6:0] cols;
    logic [3:0] ns_last;
    logic       wrap;
    logic       diag;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic write;
    logic read;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic nbr_last;
    logic state_last;
  } sts_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gnsc_ctrl.sv -----
// Controller state machine for the grid neighbor state counter.
// Sequences writes, neighbor reads and result transfers; uses gnsc_pkg.
`default_nettype none

module gnsc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          req_type,
  input  wire gnsc_pkg::sts_t sts,
  output gnsc_pkg::cmd_t     cmd,
  output logic               busy,
  output logic               done
);

  gnsc_pkg::state_t state;
  gnsc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gnsc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      gnsc_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (req_type == gnsc_pkg::REQ_QUERY) begin
            cmd.load   = 1'b1;
            state_next = gnsc_pkg::S_READ;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      gnsc_pkg::S_READ: begin
        cmd.read = 1'b1;
        if (sts.nbr_last) begin
          state_next = gnsc_pkg::S_DRAIN;
        end
      end
      gnsc_pkg::S_DRAIN: begin
        state_next = gnsc_pkg::S_EMIT;
      end
      gnsc_pkg::S_EMIT: begin
        cmd.emit = 1'b1;
        done     = 1'b1;
        if (sts.state_last) begin
          state_next = gnsc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = gnsc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/gnsc_datapath.sv -----
// Datapath for the grid neighbor state counter: cell memory, neighbor
// address generation, state tallies and result select. Uses gnsc_pkg.
`default_nettype none

module gnsc_datapath #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire gnsc_pkg::cmd_t cmd,
  input  wire gnsc_pkg::req_t req,
  input  wire gnsc_pkg::cfg_t cfg,
  output gnsc_pkg::sts_t     sts,
  output gnsc_pkg::res_t     res
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [3:0]    mem [DEPTH];
  logic [3:0]    rd_data;
  logic          rd_pend;
  logic [5:0]    cur_row;
  logic [5:0]    cur_col;
  logic          cur_inside;
  logic [2:0]    nbr_idx;
  logic [3:0]    k;
  logic [3:0]    tally [gnsc_pkg::TALLY_DEPTH];

  logic [6:0]    r;
  logic [6:0]    c;
  logic [6:0]    up;
  logic [6:0]    down;
  logic [6:0]    left;
  logic [6:0]    right;
  logic          has_up;
  logic          has_down;
  logic          has_left;
  logic          has_right;
  logic [6:0]    rsel;
  logic [6:0]    csel;
  logic          nbr_en;
  logic [6:0]    arow;
  logic [6:0]    acol;
  logic [AW-1:0] addr;
  logic          req_inside;

  assign req_inside = ({1'b0, req.row} < cfg.rows) && ({1'b0, req.col} < cfg.cols);

  assign r = {1'b0, cur_row};
  assign c = {1'b0, cur_col};

  always_comb begin
    up        = (r == 7'd0) ? cfg.rows - 7'd1 : r - 7'd1;
    down      = (cfg.wrap && (r + 7'd1 == cfg.rows)) ? 7'd0 : r + 7'd1;
    left      = (c == 7'd0) ? cfg.cols - 7'd1 : c - 7'd1;
    right     = (cfg.wrap && (c + 7'd1 == cfg.cols)) ? 7'd0 : c + 7'd1;
    has_up    = cfg.wrap || (r != 7'd0);
    has_down  = cfg.wrap || (r + 7'd1 < cfg.rows);
    has_left  = cfg.wrap || (c != 7'd0);
    has_right = cfg.wrap || (c + 7'd1 < cfg.cols);
  end

  always_comb begin
    case (nbr_idx)
      3'd0: begin rsel = r;    csel = left;  nbr_en = has_left;  end
      3'd1: begin rsel = r;    csel = right; nbr_en = has_right; end
      3'd2: begin rsel = up;   csel = c;     nbr_en = has_up;    end
      3'd3: begin rsel = down; csel = c;     nbr_en = has_down;  end
      3'd4: begin rsel = up;   csel = left;  nbr_en = cfg.diag && has_up && has_left;    end
      3'd5: begin rsel = up;   csel = right; nbr_en = cfg.diag && has_up && has_right;   end
      3'd6: begin rsel = down; csel = left;  nbr_en = cfg.diag && has_down && has_left;  end
      3'd7: begin rsel = down; csel = right; nbr_en = cfg.diag && has_down && has_right; end
      default: begin rsel = r; csel = c; nbr_en = 1'b0; end
    endcase
  end

  assign arow = cmd.write ? {1'b0, req.row} : rsel;
  assign acol = cmd.write ? {1'b0, req.col} : csel;
  assign addr = AW'(arow) * AW'(MAX_COLS) + AW'(acol);

  always_ff @(posedge clk) begin
    if (cmd.write && req_inside) begin
      mem[addr] <= req.cell_state;
    end
    if (cmd.read) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      nbr_idx <= '0;
      k       <= '0;
    end else begin
      rd_pend <= cmd.read && nbr_en && cur_inside;
      if (cmd.load) begin
        nbr_idx <= '0;
        k       <= '0;
      end else begin
        if (cmd.read) begin
          nbr_idx <= nbr_idx + 3'd1;
        end
        if (cmd.emit) begin
          k <= k + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_row    <= req.row;
      cur_col    <= req.col;
      cur_inside <= req_inside;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < gnsc_pkg::TALLY_DEPTH; i++) begin
      if (cmd.load) begin
        tally[i] <= '0;
      end else if (rd_pend && (rd_data == 4'(i))) begin
        tally[i] <= tally[i] + 4'd1;
      end
    end
  end

  assign sts.nbr_last   = (nbr_idx == gnsc_pkg::NBR_LAST);
  assign sts.state_last = (k == cfg.ns_last);

  assign res.state_index    = k;
  assign res.neighbor_count = tally[k];
  assign res.last           = sts.state_last;

endmodule

`default_nettype wire

// ----- hw/rtl/grid_neighbor_state_counter.sv -----
// Sequence: a write completes when accepted; a query is accepted, reads the eight
// neighbor slots, drains, then gives one result per cycle, one per state up to num_states.
// Throughput: one item at a time; the single-port cell memory read loop
// over eight neighbor slots sets the query time. Results cannot be stalled.
// Reset: synchronous, active high; registers return to their reset values,
// cell memory contents are not cleared.
`default_nettype none

module grid_neighbor_state_counter #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int NUM_STATES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire gnsc_pkg::req_t                req,
  output logic                               busy,
  output logic                               done,
  output gnsc_pkg::res_t                     res,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gnsc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [gnsc_pkg::DATA_W-1:0]   pwdata,
  output logic      [gnsc_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);

  localparam int STATE_LIM = (NUM_STATES < gnsc_pkg::MAX_OUT) ? NUM_STATES
                                                              : gnsc_pkg::MAX_OUT;

  logic [6:0]     grid_rows;
  logic [6:0]     grid_cols;
  logic [4:0]     num_states;
  logic           wrap_edges;
  logic           eight_neighbors;
  logic [4:0]     ns_eff;
  logic           cfg_we;
  logic [2:0]     reg_idx;
  gnsc_pkg::cfg_t cfg;
  gnsc_pkg::cmd_t cmd;
  gnsc_pkg::sts_t sts;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows       <= gnsc_pkg::GRID_ROWS_RST;
      grid_cols       <= gnsc_pkg::GRID_COLS_RST;
      num_states      <= gnsc_pkg::NUM_STATES_RST;
      wrap_edges      <= 1'b0;
      eight_neighbors <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx)
        gnsc_pkg::REG_GRID_ROWS:  grid_rows       <= pwdata[6:0];
        gnsc_pkg::REG_GRID_COLS:  grid_cols       <= pwdata[6:0];
        gnsc_pkg::REG_NUM_STATES: num_states      <= pwdata[4:0];
        gnsc_pkg::REG_WRAP_EDGES: wrap_edges      <= pwdata[0];
        gnsc_pkg::REG_EIGHT_NBRS: eight_neighbors <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gnsc_pkg::REG_GRID_ROWS:  prdata = {25'd0, grid_rows};
      gnsc_pkg::REG_GRID_COLS:  prdata = {25'd0, grid_cols};
      gnsc_pkg::REG_NUM_STATES: prdata = {27'd0, num_states};
      gnsc_pkg::REG_WRAP_EDGES: prdata = {31'd0, wrap_edges};
      gnsc_pkg::REG_EIGHT_NBRS: prdata = {31'd0, eight_neighbors};
      default:                  prdata = '0;
    endcase
  end

  always_comb begin
    if (grid_rows == 7'd0) begin
      cfg.rows = 7'd1;
    end else if (32'(grid_rows) > MAX_ROWS) begin
      cfg.rows = 7'(MAX_ROWS);
    end else begin
      cfg.rows = grid_rows;
    end
    if (grid_cols == 7'd0) begin
      cfg.cols = 7'd1;
    end else if (32'(grid_cols) > MAX_COLS) begin
      cfg.cols = 7'(MAX_COLS);
    end else begin
      cfg.cols = grid_cols;
    end
    if (num_states == 5'd0) begin
      ns_eff = 5'd1;
    end else if (32'(num_states) > STATE_LIM) begin
      ns_eff = 5'(STATE_LIM);
    end else begin
      ns_eff = num_states;
    end
    cfg.ns_last = 4'(ns_eff - 5'd1);
    cfg.wrap    = wrap_edges;
    cfg.diag    = eight_neighbors;
  end

  gnsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req.req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  gnsc_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .cfg (cfg),
    .sts (sts),
    .res (res)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/gnsc_checker.sv -----
// Port-level checker for the grid neighbor state counter, bound to the top.
// Uses gnsc_pkg for the payload types.
`default_nettype none

module gnsc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire gnsc_pkg::req_t req,
  input wire logic busy,
  input wire logic done,
  input wire gnsc_pkg::res_t res
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result transfer while not busy");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.req_type == gnsc_pkg::REQ_QUERY) |=> busy)
    else $error("query accepted without going busy");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (done && !res.last) |=> (done && res.state_index == $past(res.state_index) + 4'd1))
    else $error("result sequence broken");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (res.neighbor_count <= 4'd8))
    else $error("neighbor count out of range");

  a_last_end: assert property (@(posedge clk) disable iff (rst)
    (done && res.last) |=> !done)
    else $error("result after last");

endmodule

bind grid_neighbor_state_counter gnsc_checker u_gnsc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .req   (req),
  .busy  (busy),
  .done  (done),
  .res   (res)
);

`default_nettype wire
